FILE: design/lcd_slt_pkg.sv
// Shared types and constants for the LCD scanline timing controller.
// Holds mode codes, line limits, mode thresholds and register indexes.
// No dependencies.
package lcd_slt_pkg;

    // LCD mode codes
    typedef enum logic [1:0] {
        MODE_HBLANK   = 2'd0,
        MODE_VBLANK   = 2'd1,
        MODE_SEARCH   = 2'd2,
        MODE_TRANSFER = 2'd3
    } lcd_mode_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_LCD_CONTROL    = 2'd0,
        REG_STATUS_ENABLES = 2'd1,
        REG_COMPARE_LINE   = 2'd2,
        REG_UNUSED         = 2'd3
    } cfg_index_t;

    localparam int LINE_CYCLES_DEF = 456;
    localparam int MODE2_FROM      = 376;
    localparam int MODE3_FROM      = 204;

    localparam logic [7:0] VBLANK_LINE = 8'd144;
    localparam logic [7:0] LAST_LINE   = 8'd153;

    // lcd_control bit positions
    localparam int CTRL_DISPLAY_BIT = 7;
    localparam int CTRL_SPRITE_BIT  = 1;
    localparam int CTRL_BG_BIT      = 0;

    // status_enables bit positions
    localparam int SEN_MODE0_BIT = 0;
    localparam int SEN_MODE1_BIT = 1;
    localparam int SEN_MODE2_BIT = 2;
    localparam int SEN_MATCH_BIT = 3;

endpackage

FILE: design/lcd_scanline_timing_controller_top.sv
// LCD scanline timing controller: one step of the line and mode timing per beat.
// Depends on lcd_slt_pkg for mode codes, limits and register indexes.
//
// Usage:
//   Input channel (in_valid/in_stall) carries elapsed_cycles, the number of
//   clocks that passed since the previous beat. Each input beat yields exactly
//   one result beat on the output channel (out_valid/out_stall) carrying the
//   mode, the line after the step, the line-compare flag and the status,
//   vblank and draw requests.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write
//   only while no beat is in flight.
//   An accepted beat lands in the input register; its result is captured
//   in the output register, raising out_valid, once that register is free.
//   Throughput: one beat per cycle unless out_stall holds a result.
//   The line countdown is a single compare and subtract between the input
//   register and the state registers.
//   Stall: when out_stall holds a result, the input register holds too and
//   in_stall rises once it is full; nothing is dropped or repeated.
//   Reset: empty pipeline, lcd_control = 145, other registers 0, line 0,
//   mode 1, full line countdown, match flag clear.
module lcd_scanline_timing_controller_top #(
    parameter int LINE_CYCLES = lcd_slt_pkg::LINE_CYCLES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] elapsed_cycles,
    // output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] lcd_mode,
    output logic [7:0] current_line,
    output logic       line_match,
    output logic       status_interrupt,
    output logic       vblank_irq,
    output logic       draw_request,
    output logic       draw_background,
    output logic       draw_sprites
);
    import lcd_slt_pkg::*;

    localparam int CNT_W = $clog2(LINE_CYCLES + 1);
    localparam logic [CNT_W-1:0] CNT_RELOAD = CNT_W'(LINE_CYCLES);
    localparam logic [CNT_W-1:0] CNT_MODE2  = CNT_W'(MODE2_FROM);
    localparam logic [CNT_W-1:0] CNT_MODE3  = CNT_W'(MODE3_FROM);

    // configuration registers
    logic [7:0] lcd_control_reg;
    logic [3:0] status_enables_reg;
    logic [7:0] compare_line_reg;

    // timing state
    logic [CNT_W-1:0] cycles_left_reg, cycles_left_next;
    logic [7:0]       line_reg, line_next;
    lcd_mode_t        mode_reg, mode_next;
    logic             match_reg, match_next;

    // input register
    logic       in_valid_reg;
    logic [7:0] elapsed_reg;

    // output register
    logic       out_valid_reg;
    logic [1:0] lcd_mode_reg;
    logic [7:0] current_line_reg;
    logic       line_match_reg;
    logic       status_irq_reg, status_irq_next;
    logic       vblank_irq_reg, vblank_irq_next;
    logic       draw_req_reg, draw_req_next;
    logic       draw_bg_reg;
    logic       draw_spr_reg;

    logic out_free;
    logic advance;
    logic in_accept;

    logic [CNT_W-1:0] elapsed_ext;
    logic [7:0]       line_inc;
    logic             line_done;
    logic             mode_irq_en;
    logic             display_on;

    // handshake: result slot frees when empty or being taken
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcd_control_reg    <= 8'd145;
            status_enables_reg <= 4'd0;
            compare_line_reg   <= 8'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_LCD_CONTROL:    lcd_control_reg    <= cfg_data;
                REG_STATUS_ENABLES: status_enables_reg <= cfg_data[3:0];
                REG_COMPARE_LINE:   compare_line_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            elapsed_reg <= elapsed_cycles;
        end
    end

    // step logic: evaluate mode and match, then advance the countdown
    assign display_on  = lcd_control_reg[CTRL_DISPLAY_BIT];
    assign elapsed_ext = CNT_W'(elapsed_reg);
    assign line_inc    = line_reg + 8'd1;
    assign line_done   = (elapsed_ext >= cycles_left_reg);

    always_comb
    begin
        mode_next        = mode_reg;
        match_next       = match_reg;
        cycles_left_next = cycles_left_reg;
        line_next        = line_reg;
        status_irq_next  = 1'b0;
        vblank_irq_next  = 1'b0;
        draw_req_next    = 1'b0;
        mode_irq_en      = 1'b0;

        if (!display_on)
        begin
            // hold line 0 in vblank with a full countdown
            mode_next        = MODE_VBLANK;
            line_next        = 8'd0;
            cycles_left_next = CNT_RELOAD;
        end
        else
        begin
            priority if (line_reg >= VBLANK_LINE)
                mode_next = MODE_VBLANK;
            else if (cycles_left_reg >= CNT_MODE2)
                mode_next = MODE_SEARCH;
            else if (cycles_left_reg >= CNT_MODE3)
                mode_next = MODE_TRANSFER;
            else
                mode_next = MODE_HBLANK;

            unique case (mode_next)
                MODE_HBLANK:   mode_irq_en = status_enables_reg[SEN_MODE0_BIT];
                MODE_VBLANK:   mode_irq_en = status_enables_reg[SEN_MODE1_BIT];
                MODE_SEARCH:   mode_irq_en = status_enables_reg[SEN_MODE2_BIT];
                MODE_TRANSFER: mode_irq_en = 1'b0;
                default:       mode_irq_en = 1'b0;
            endcase

            match_next      = (line_reg == compare_line_reg);
            status_irq_next = ((mode_next != mode_reg) && mode_irq_en)
                              || (match_next && status_enables_reg[SEN_MATCH_BIT]);

            if (line_done)
            begin
                cycles_left_next = CNT_RELOAD;
                line_next        = (line_inc > LAST_LINE) ? 8'd0 : line_inc;
                vblank_irq_next  = (line_next == VBLANK_LINE);
                draw_req_next    = (line_next < VBLANK_LINE);
            end
            else
            begin
                cycles_left_next = cycles_left_reg - elapsed_ext;
            end
        end
    end

    // timing state, updated once per processed beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycles_left_reg <= CNT_RELOAD;
            line_reg        <= 8'd0;
            mode_reg        <= MODE_VBLANK;
            match_reg       <= 1'b0;
        end
        else if (advance)
        begin
            cycles_left_reg <= cycles_left_next;
            line_reg        <= line_next;
            mode_reg        <= mode_next;
            match_reg       <= match_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lcd_mode_reg     <= mode_next;
            current_line_reg <= line_next;
            line_match_reg   <= match_next;
            status_irq_reg   <= status_irq_next;
            vblank_irq_reg   <= vblank_irq_next;
            draw_req_reg     <= draw_req_next;
            draw_bg_reg      <= draw_req_next && lcd_control_reg[CTRL_BG_BIT];
            draw_spr_reg     <= draw_req_next && lcd_control_reg[CTRL_SPRITE_BIT];
        end
    end

    assign out_valid        = out_valid_reg;
    assign lcd_mode         = lcd_mode_reg;
    assign current_line     = current_line_reg;
    assign line_match       = line_match_reg;
    assign status_interrupt = status_irq_reg;
    assign vblank_irq       = vblank_irq_reg;
    assign draw_request     = draw_req_reg;
    assign draw_background  = draw_bg_reg;
    assign draw_sprites     = draw_spr_reg;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for lcd_scanline_timing_controller_top: line and mode timing,
// status/vblank interrupts and draw requests checked beat by beat against a local predictor.
// Depends on lcd_slt_pkg and the RTL of lcd_scanline_timing_controller_top.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lcd_slt_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;

    // Expected outputs of one timing step
    typedef struct packed {
        lcd_mode_t  mode;
        logic [7:0] line;
        logic       match;
        logic       stat_irq;
        logic       vblank_irq;
        logic       draw;
        logic       draw_bg;
        logic       draw_spr;
    } line_step_t;

    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       cfg_we         = 1'b0;
    logic [1:0] cfg_index      = REG_LCD_CONTROL;
    logic [7:0] cfg_data       = 8'd0;
    logic       in_valid       = 1'b0;
    logic       in_stall;
    logic [7:0] elapsed_cycles = 8'd0;
    logic       out_valid;
    logic       out_stall      = 1'b0;
    logic [1:0] lcd_mode;
    logic [7:0] current_line;
    logic       line_match;
    logic       status_interrupt;
    logic       vblank_irq;
    logic       draw_request;
    logic       draw_background;
    logic       draw_sprites;

    // Shadow copy of the configuration registers
    logic [7:0] ctrl_reg;
    logic [3:0] stat_en;
    logic [7:0] cmp_line;

    // Shadow copy of the timing state
    logic [9:0] cyc_left;
    logic [7:0] line_no;
    lcd_mode_t  mode_q;
    logic       match_q;

    line_step_t pending_steps[$];
    int         err_count = 0;
    int         cycle_count = 0;
    bit         idle_en = 1'b1;
    bit         hold_off = 1'b0;
    int         stall_run = 0;

    lcd_scanline_timing_controller_top DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .elapsed_cycles   (elapsed_cycles),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .lcd_mode         (lcd_mode),
        .current_line     (current_line),
        .line_match       (line_match),
        .status_interrupt (status_interrupt),
        .vblank_irq       (vblank_irq),
        .draw_request     (draw_request),
        .draw_background  (draw_background),
        .draw_sprites     (draw_sprites)
    );

    always #5 clk = ~clk;

    // Bring shadow registers and timing state to their reset values
    function automatic void timing_reset();
        ctrl_reg = 8'd145;
        stat_en  = 4'd0;
        cmp_line = 8'd0;
        cyc_left = 10'(LINE_CYCLES_DEF);
        line_no  = 8'd0;
        mode_q   = MODE_VBLANK;
        match_q  = 1'b0;
    endfunction

    // Advance the timing state by one beat and queue the outputs it must produce
    function automatic void advance_timing(input logic [7:0] elapsed);
        line_step_t step;
        lcd_mode_t  next_mode;
        step = '0;
        if (!ctrl_reg[CTRL_DISPLAY_BIT])
        begin
            cyc_left = 10'(LINE_CYCLES_DEF);
            line_no  = 8'd0;
            mode_q   = MODE_VBLANK;
        end
        else
        begin
            if (line_no >= VBLANK_LINE)
                next_mode = MODE_VBLANK;
            else if (cyc_left >= 10'(MODE2_FROM))
                next_mode = MODE_SEARCH;
            else if (cyc_left >= 10'(MODE3_FROM))
                next_mode = MODE_TRANSFER;
            else
                next_mode = MODE_HBLANK;

            // Mode entry raises status only for modes that have an enable bit
            if (next_mode != mode_q)
            begin
                case (next_mode)
                    MODE_HBLANK: step.stat_irq = stat_en[SEN_MODE0_BIT];
                    MODE_VBLANK: step.stat_irq = stat_en[SEN_MODE1_BIT];
                    MODE_SEARCH: step.stat_irq = stat_en[SEN_MODE2_BIT];
                    default:     step.stat_irq = 1'b0;
                endcase
            end

            // Line compare is level sensitive, not edge
            match_q = (line_no == cmp_line);
            if (match_q && stat_en[SEN_MATCH_BIT])
                step.stat_irq = 1'b1;
            mode_q = next_mode;

            if (10'(elapsed) >= cyc_left)
            begin
                cyc_left = 10'(LINE_CYCLES_DEF);
                line_no  = line_no + 8'd1;
                if (line_no > LAST_LINE)
                    line_no = 8'd0;
                if (line_no == VBLANK_LINE)
                    step.vblank_irq = 1'b1;
                else if (line_no < VBLANK_LINE)
                    step.draw = 1'b1;
            end
            else
            begin
                cyc_left = cyc_left - 10'(elapsed);
            end
        end
        step.mode     = mode_q;
        step.line     = line_no;
        step.match    = match_q;
        step.draw_bg  = step.draw & ctrl_reg[CTRL_BG_BIT];
        step.draw_spr = step.draw & ctrl_reg[CTRL_SPRITE_BIT];
        pending_steps.push_back(step);
    endfunction

    // Mostly long strides so frames get crossed, with extremes and full-range noise
    function automatic logic [7:0] pick_elapsed();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return 8'd0;
            1:       return 8'd255;
            2, 3:    return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(160, 255));
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        err_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Write one register; the bus is idle by contract
    task automatic write_reg(input cfg_index_t idx, input logic [7:0] data);
        case (idx)
            REG_LCD_CONTROL:    ctrl_reg = data;
            REG_STATUS_ENABLES: stat_en  = data[3:0];
            REG_COMPARE_LINE:   cmp_line = data;
            default:            ;
        endcase
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one beat, with an occasional idle burst ahead of it
    task automatic send_elapsed(input logic [7:0] val);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        elapsed_cycles <= val;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drop valid and wait for every expected beat, then let the pipe settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_steps.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Predict on every accepted input beat
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            advance_timing(elapsed_cycles);
    end

    // Compare every accepted output beat with the oldest prediction
    always @(posedge clk)
    begin
        line_step_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_steps.size() == 0)
            begin
                report_mismatch("result beat with no prediction pending");
            end
            else
            begin
                want = pending_steps.pop_front();
                check_field("lcd_mode", lcd_mode, want.mode);
                check_field("current_line", current_line, want.line);
                check_field("line_match", line_match, want.match);
                check_field("status_interrupt", status_interrupt, want.stat_irq);
                check_field("vblank_irq", vblank_irq, want.vblank_irq);
                check_field("draw_request", draw_request, want.draw);
                check_field("draw_background", draw_background, want.draw_bg);
                check_field("draw_sprites", draw_sprites, want.draw_spr);
            end
        end
    end

    // Receiver: random stall bursts, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_off)
        begin
            out_stall <= 1'b1;
        end
        else if (stall_run != 0)
        begin
            out_stall <= 1'b1;
            stall_run <= stall_run - 1;
        end
        else if (idle_en && $urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            stall_run <= $urandom_range(0, 16);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("lcd_scanline_timing_controller_top verification failed");
            $finish;
        end
    end

    // Reset defaults: display on, walk one line through search, transfer, hblank
    task automatic test_power_on();
        send_elapsed(8'd0);
        send_elapsed(8'd100);
        send_elapsed(8'd100);
        send_elapsed(8'd60);
        send_elapsed(8'd255);
        send_elapsed(8'd255);
        wait_drained();
    endtask

    // All status sources enabled; upper enable bits must be masked off
    task automatic test_status_sources();
        write_reg(REG_STATUS_ENABLES, 8'hFF);
        write_reg(REG_COMPARE_LINE, 8'd2);
        send_elapsed(8'd0);
        send_elapsed(8'd90);
        send_elapsed(8'd90);
        send_elapsed(8'd90);
        send_elapsed(8'd200);
        send_elapsed(8'd0);
        send_elapsed(8'd255);
        send_elapsed(8'd255);
        wait_drained();
    endtask

    // Display off holds line 0 in vblank mode; unused index must be ignored
    task automatic test_display_off();
        write_reg(REG_LCD_CONTROL, 8'h7F);
        send_elapsed(8'd255);
        send_elapsed(8'd0);
        send_elapsed(8'd37);
        wait_drained();
        write_reg(REG_LCD_CONTROL, 8'h83);
        write_reg(REG_UNUSED, 8'h00);
        send_elapsed(8'd255);
        send_elapsed(8'd255);
        send_elapsed(8'd128);
        wait_drained();
    endtask

    // Run past a frame end while the receiver holds off long enough to fill the pipe
    task automatic test_frame_wrap();
        write_reg(REG_LCD_CONTROL, 8'h83);
        write_reg(REG_STATUS_ENABLES, 8'($urandom_range(0, 15)));
        write_reg(REG_COMPARE_LINE, LAST_LINE);
        fork
            begin
                repeat (40) @(posedge clk);
                hold_off <= 1'b1;
                repeat (120) @(posedge clk);
                hold_off <= 1'b0;
            end
            begin
                for (int i = 0; i < 340; i++)
                begin
                    idle_en <= (i < 200 || i > 260);
                    if ($urandom_range(0, 9) == 0)
                        send_elapsed(8'($urandom_range(0, 255)));
                    else
                        send_elapsed(8'($urandom_range(224, 255)));
                end
            end
        join
        idle_en <= 1'b1;
        wait_drained();
    endtask

    // Random phases over several register settings; the last one runs without idling
    task automatic test_random_phases();
        logic [7:0] ctrl_v;
        logic [7:0] sen_v;
        logic [7:0] cmp_v;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:
                begin
                    ctrl_v = 8'hFF;
                    sen_v  = 8'h0F;
                    cmp_v  = 8'd0;
                end
                1:
                begin
                    ctrl_v = 8'h00;
                    sen_v  = 8'h00;
                    cmp_v  = 8'hFF;
                end
                2:
                begin
                    ctrl_v = 8'h80 | 8'($urandom_range(0, 255));
                    sen_v  = 8'($urandom_range(0, 255));
                    cmp_v  = 8'($urandom_range(0, 153));
                end
                default:
                begin
                    ctrl_v = 8'($urandom_range(0, 255));
                    sen_v  = 8'($urandom_range(0, 255));
                    cmp_v  = 8'($urandom_range(0, 255));
                end
            endcase
            write_reg(REG_LCD_CONTROL, ctrl_v);
            write_reg(REG_STATUS_ENABLES, sen_v);
            write_reg(REG_COMPARE_LINE, cmp_v);
            idle_en <= (phase != 4);
            for (int i = 0; i < 52; i++)
                send_elapsed(pick_elapsed());
            wait_drained();
        end
    endtask

    initial
    begin
        timing_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on();
        test_status_sources();
        test_display_off();
        test_frame_wrap();
        test_random_phases();

        if (err_count == 0)
            $display("lcd_scanline_timing_controller_top verification clean");
        else
            $display("lcd_scanline_timing_controller_top verification failed");
        $finish;
    end

endmodule

FILE: files.f
design/lcd_slt_pkg.sv
design/lcd_scanline_timing_controller_top.sv
tb/tb_top.sv
